>>> design/ust_pkg.sv
// Package: shared types, codes and constants of the element session tracker.
`timescale 1ns / 1ps

package ust_pkg;

    localparam int ENTRIES_DEFAULT = 64;
    localparam int ID_W            = 32;
    localparam int GEN_W           = 32;
    localparam int CNT_W           = 32;

    localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};
    localparam logic [CNT_W-1:0] COUNT_ONE = {{(CNT_W-1){1'b0}}, 1'b1};
    localparam logic [GEN_W-1:0] GEN_ONE   = {{(GEN_W-1){1'b0}}, 1'b1};
    localparam logic [GEN_W-1:0] GEN_ZERO  = {GEN_W{1'b0}};

    typedef enum logic [1:0] {
        OP_ADVANCE  = 2'd0,
        OP_REGISTER = 2'd1,
        OP_QUERY    = 2'd2,
        OP_RELEASE  = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_UPDATE,
        ST_REPORT
    } state_t;

    typedef struct packed {
        op_t              op;
        logic [ID_W-1:0]  element_id;
    } request_t;

    typedef struct packed {
        logic answer;
        logic found;
        logic any_current;
    } result_t;

    typedef struct packed {
        logic             valid;
        logic [ID_W-1:0]  id;
        logic [GEN_W-1:0] gen;
        logic [CNT_W-1:0] count;
    } entry_t;

    // Broadcast from the sequencer to every cell.
    typedef struct packed {
        logic             load;     // latch the id compare for a new request
        logic             apply;    // update cycle
        logic             clear;    // empty the table on generation wrap
        logic             append;   // register of an absent id, table not full
        op_t              op;
        logic [ID_W-1:0]  req_id;
        logic [ID_W-1:0]  load_id;
        logic [GEN_W-1:0] cur_gen;
    } cell_ctrl_t;

    // Per-cell status gathered by the top level.
    typedef struct packed {
        logic hit;          // id matched at request acceptance
        logic hit_current;  // matched and stamped with the current generation
        logic hit_last;     // matched and count of one or less
        logic current;      // valid and stamped with the current generation
    } cell_stat_t;

endpackage

>>> design/ust_cell.sv
// One table slot: holds an entry, compares its id and shifts towards the head.
`timescale 1ns / 1ps

module ust_cell (
    input  logic                clk,
    input  logic                rst_n,
    input  ust_pkg::cell_ctrl_t ctrl,
    input  logic                shift_in,
    output logic                shift_out,
    input  logic                prev_valid,
    input  ust_pkg::entry_t     upper,
    output ust_pkg::entry_t     own,
    output ust_pkg::cell_stat_t stat
);

    logic                      valid_reg, valid_next;
    logic [ust_pkg::ID_W-1:0]  id_reg, id_next;
    logic [ust_pkg::GEN_W-1:0] gen_reg, gen_next;
    logic [ust_pkg::CNT_W-1:0] count_reg, count_next;
    logic                      hit_reg, hit_next;

    logic count_le1;
    logic gen_cur;
    logic remove_here;
    logic shift;
    logic append_here;

    assign count_le1   = ~|count_reg[ust_pkg::CNT_W-1:1];
    assign gen_cur     = (gen_reg == ctrl.cur_gen);
    assign remove_here = hit_reg && (ctrl.op == ust_pkg::OP_RELEASE) && count_le1;
    assign shift       = ctrl.apply && (shift_in || remove_here);
    assign shift_out   = shift;
    assign append_here = ctrl.apply && ctrl.append && prev_valid && !valid_reg;

    always_comb
    begin
        hit_next = hit_reg;
        if (ctrl.load)
        begin
            hit_next = valid_reg && (id_reg == ctrl.load_id);
        end
    end

    always_comb
    begin
        valid_next = valid_reg;
        id_next    = id_reg;
        gen_next   = gen_reg;
        count_next = count_reg;
        if (ctrl.apply && ctrl.clear)
        begin
            valid_next = 1'b0;
        end
        else if (shift)
        begin
            valid_next = upper.valid;
            id_next    = upper.id;
            gen_next   = upper.gen;
            count_next = upper.count;
        end
        else if (append_here)
        begin
            valid_next = 1'b1;
            id_next    = ctrl.req_id;
            gen_next   = ctrl.cur_gen;
            count_next = ust_pkg::COUNT_ONE;
        end
        else if (ctrl.apply && hit_reg && (ctrl.op == ust_pkg::OP_REGISTER))
        begin
            gen_next = ctrl.cur_gen;
            if (count_reg != ust_pkg::COUNT_MAX)
            begin
                count_next = count_reg + ust_pkg::COUNT_ONE;
            end
        end
        else if (ctrl.apply && hit_reg && (ctrl.op == ust_pkg::OP_RELEASE))
        begin
            count_next = count_reg - ust_pkg::COUNT_ONE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            hit_reg   <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            hit_reg   <= hit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        id_reg    <= id_next;
        gen_reg   <= gen_next;
        count_reg <= count_next;
    end

    assign own.valid = valid_reg;
    assign own.id    = id_reg;
    assign own.gen   = gen_reg;
    assign own.count = count_reg;

    assign stat.hit         = hit_reg;
    assign stat.hit_current = hit_reg && gen_cur;
    assign stat.hit_last    = hit_reg && count_le1;
    assign stat.current     = valid_reg && gen_cur;

endmodule

>>> design/ui_element_session_tracker.sv
// Top level: request sequencer and the chain of table cells.
`timescale 1ns / 1ps

// A request is compared against the table when it is accepted, updates the table in the
// UPDATE state and gives its result, with done high, in the REPORT state that follows.
// Busy is high only in the update cycle, so a new request is taken in the same cycle
// that the previous result is shown. The receiver cannot stall: done lasts one cycle
// and the result is held only until the next update.
// Reset (rst_n low, asynchronous) empties the table and sets the generation to zero.
module ui_element_session_tracker #(
    parameter int ENTRIES = ust_pkg::ENTRIES_DEFAULT
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  ust_pkg::request_t request,
    output logic              busy,
    output logic              done,
    output ust_pkg::result_t  result
);

    // Sequencer state.
    ust_pkg::state_t            state_reg, state_next;
    ust_pkg::op_t               op_reg, op_next;
    logic [ust_pkg::ID_W-1:0]   req_id_reg, req_id_next;
    logic [ust_pkg::GEN_W-1:0]  gen_reg, gen_next;
    logic                       answer_reg, answer_next;
    logic                       found_reg, found_next;

    logic                       accept;
    logic                       update;
    logic [ust_pkg::GEN_W-1:0]  gen_inc;
    logic                       wrap;
    logic                       found;
    logic                       full;
    logic                       evict;

    ust_pkg::cell_ctrl_t        ctrl;
    ust_pkg::entry_t            tail;

    // Chain wiring: entry and shift flags run between neighbouring cells.
    ust_pkg::entry_t            own  [ENTRIES];
    ust_pkg::cell_stat_t        stat [ENTRIES];
    logic [ENTRIES:0]           shift_chain;
    logic [ENTRIES-1:0]         hit_vec;
    logic [ENTRIES-1:0]         hit_cur_vec;
    logic [ENTRIES-1:0]         hit_last_vec;
    logic [ENTRIES-1:0]         cur_vec;

    // A request enters while idle or while the previous result is shown.
    assign accept = start && !busy;
    assign update = (state_reg == ust_pkg::ST_UPDATE);

    // Next-state logic.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ust_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ust_pkg::ST_UPDATE;
                end
            end
            ust_pkg::ST_UPDATE:
            begin
                state_next = ust_pkg::ST_REPORT;
            end
            ust_pkg::ST_REPORT:
            begin
                state_next = accept ? ust_pkg::ST_UPDATE : ust_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = ust_pkg::ST_IDLE;
            end
        endcase
    end

    // Handshake outputs.
    always_comb
    begin
        busy = 1'b0;
        done = 1'b0;
        case (state_reg)
            ust_pkg::ST_IDLE:
            begin
                busy = 1'b0;
            end
            ust_pkg::ST_UPDATE:
            begin
                busy = 1'b1;
            end
            ust_pkg::ST_REPORT:
            begin
                done = 1'b1;
            end
            default:
            begin
                busy = 1'b0;
            end
        endcase
    end

    // Global flags of the update cycle: the ids are unique, so at most one cell hits.
    assign found = |hit_vec;
    assign full  = own[ENTRIES-1].valid;
    assign evict = (op_reg == ust_pkg::OP_REGISTER) && !found && full;

    assign gen_inc = gen_reg + ust_pkg::GEN_ONE;
    assign wrap    = (gen_inc == ust_pkg::GEN_ZERO);

    // Hold the request; advance the generation; register the answer in the update cycle.
    always_comb
    begin
        op_next     = op_reg;
        req_id_next = req_id_reg;
        gen_next    = gen_reg;
        answer_next = answer_reg;
        found_next  = found_reg;
        if (accept)
        begin
            op_next     = request.op;
            req_id_next = request.element_id;
        end
        if (update)
        begin
            case (op_reg)
                ust_pkg::OP_ADVANCE:
                begin
                    gen_next    = wrap ? ust_pkg::GEN_ONE : gen_inc;
                    answer_next = 1'b0;
                    found_next  = 1'b0;
                end
                ust_pkg::OP_REGISTER:
                begin
                    answer_next = 1'b1;
                    found_next  = found;
                end
                ust_pkg::OP_QUERY:
                begin
                    answer_next = |hit_cur_vec;
                    found_next  = found;
                end
                ust_pkg::OP_RELEASE:
                begin
                    // Removed only when the count was one or less.
                    answer_next = |(hit_cur_vec & hit_last_vec);
                    found_next  = found;
                end
                default:
                begin
                    answer_next = 1'b0;
                    found_next  = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ust_pkg::ST_IDLE;
            op_reg    <= ust_pkg::OP_ADVANCE;
            gen_reg   <= ust_pkg::GEN_ZERO;
        end
        else
        begin
            state_reg <= state_next;
            op_reg    <= op_next;
            gen_reg   <= gen_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_id_reg <= req_id_next;
        answer_reg <= answer_next;
        found_reg  <= found_next;
    end

    // Broadcast to the cells. The id compare is taken straight from the request port
    // at acceptance, so the update can follow in the very next cycle.
    assign ctrl.load    = accept;
    assign ctrl.apply   = update;
    assign ctrl.clear   = (op_reg == ust_pkg::OP_ADVANCE) && wrap;
    assign ctrl.append  = (op_reg == ust_pkg::OP_REGISTER) && !found && !full;
    assign ctrl.op      = op_reg;
    assign ctrl.req_id  = req_id_reg;
    assign ctrl.load_id = request.element_id;
    assign ctrl.cur_gen = gen_reg;

    // The youngest cell shifts in the new entry on eviction, or an empty slot on removal.
    assign tail.valid = evict;
    assign tail.id    = req_id_reg;
    assign tail.gen   = gen_reg;
    assign tail.count = ust_pkg::COUNT_ONE;

    // Eviction drops the oldest entry, so the whole chain shifts from cell 0.
    assign shift_chain[0] = evict;

    genvar i;
    generate
        for (i = 0; i < ENTRIES; i++)
        begin : g_cell
            ust_pkg::entry_t upper_in;
            logic            prev_valid_in;

            if (i == ENTRIES - 1)
            begin : g_tail
                assign upper_in = tail;
            end
            else
            begin : g_mid
                assign upper_in = own[i+1];
            end

            if (i == 0)
            begin : g_head
                assign prev_valid_in = 1'b1;
            end
            else
            begin : g_body
                assign prev_valid_in = own[i-1].valid;
            end

            ust_cell u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .ctrl       (ctrl),
                .shift_in   (shift_chain[i]),
                .shift_out  (shift_chain[i+1]),
                .prev_valid (prev_valid_in),
                .upper      (upper_in),
                .own        (own[i]),
                .stat       (stat[i])
            );

            assign hit_vec[i]      = stat[i].hit;
            assign hit_cur_vec[i]  = stat[i].hit_current;
            assign hit_last_vec[i] = stat[i].hit_last;
            assign cur_vec[i]      = stat[i].current;
        end
    endgenerate

    // any_current is read from the table as it stands after the update.
    assign result.answer      = answer_reg;
    assign result.found       = found_reg;
    assign result.any_current = |cur_vec;

endmodule

>>> design/ust_checker.sv
// Checker: port-level timing and result properties of the session tracker.
`timescale 1ns / 1ps

module ust_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              start,
    input ust_pkg::request_t request,
    input logic              busy,
    input logic              done,
    input ust_pkg::result_t  result
);

    // A result is shown while the next request may already enter.
    a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("done raised while busy");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("busy not raised after an accepted request");

    a_accept_done: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##2 done)
        else $error("result missing two cycles after acceptance");

    a_advance_result: assert property (@(posedge clk) disable iff (!rst_n)
        (done && ($past(request.op, 2) == ust_pkg::OP_ADVANCE))
            |-> (!result.answer && !result.found))
        else $error("advance reported a match");

    a_register_result: assert property (@(posedge clk) disable iff (!rst_n)
        (done && ($past(request.op, 2) == ust_pkg::OP_REGISTER))
            |-> (result.answer && result.any_current))
        else $error("register left no current entry");

endmodule

bind ui_element_session_tracker ust_checker u_ust_checker (.*);

>>> verif/ui_element_session_tracker_tb.sv
// Testbench: element session tracker checked against a table predictor.
`timescale 1ns / 1ps

module ui_element_session_tracker_tb;

    localparam int TABLE_DEPTH = ust_pkg::ENTRIES_DEFAULT;
    // The limit leaves a wide margin over the slowest correct run.
    localparam int CYCLE_LIMIT = 200000;
    localparam int PRINT_LIMIT = 40;

    logic              clk;
    logic              rst_n   = 1'b0;
    logic              start   = 1'b0;
    ust_pkg::request_t request = '0;
    logic              busy;
    logic              done;
    ust_pkg::result_t  result;

    // Predictor state: age-ordered table, slot 0 the oldest.
    logic [ust_pkg::ID_W-1:0]  tab_id  [TABLE_DEPTH];
    logic [ust_pkg::GEN_W-1:0] tab_gen [TABLE_DEPTH];
    logic [ust_pkg::CNT_W-1:0] tab_cnt [TABLE_DEPTH];
    int                        tab_fill;
    logic [ust_pkg::GEN_W-1:0] cur_gen;

    // Outcomes predicted for accepted requests, oldest first.
    ust_pkg::result_t          session_outcomes[$];

    logic [ust_pkg::ID_W-1:0]  id_pool[$];
    int                        mismatch_count;
    int                        cycle_count;
    int                        burst_left;
    bit                        no_gaps;

    ui_element_session_tracker #(
        .ENTRIES (TABLE_DEPTH)
    ) DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .request (request),
        .busy    (busy),
        .done    (done),
        .result  (result)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Guard against a hung handshake.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    task automatic report_mismatch(input string what, input logic got, input logic want);
        if (mismatch_count < PRINT_LIMIT)
            $display("mismatch at %0t: %s got %0b want %0b", $realtime, what, got, want);
        mismatch_count++;
    endtask

    // Remove one entry and close the gap by shifting the younger entries down.
    task automatic drop_entry(input int pos);
        int i;
        for (i = pos; i + 1 < tab_fill; i++)
        begin
            tab_id[i]  = tab_id[i + 1];
            tab_gen[i] = tab_gen[i + 1];
            tab_cnt[i] = tab_cnt[i + 1];
        end
        tab_fill--;
    endtask

    // Advance the predicted table by one request and queue its outcome.
    task automatic track_session(input ust_pkg::request_t req);
        ust_pkg::result_t outcome;
        int               pos;
        int               i;
        logic             was_current;
        outcome = '0;
        pos     = -1;
        if (req.op == ust_pkg::OP_ADVANCE)
        begin
            cur_gen = cur_gen + ust_pkg::GEN_ONE;
            // Wrap to zero: restart at one with an empty table.
            if (cur_gen == ust_pkg::GEN_ZERO)
            begin
                cur_gen  = ust_pkg::GEN_ONE;
                tab_fill = 0;
            end
        end
        else
        begin
            for (i = 0; i < tab_fill; i++)
                if (pos < 0 && tab_id[i] == req.element_id)
                    pos = i;
            outcome.found = (pos >= 0);
            case (req.op)
                ust_pkg::OP_REGISTER:
                begin
                    if (pos >= 0)
                    begin
                        // Saturate the count, but restamp in every case.
                        if (tab_cnt[pos] != ust_pkg::COUNT_MAX)
                            tab_cnt[pos] = tab_cnt[pos] + ust_pkg::COUNT_ONE;
                        tab_gen[pos] = cur_gen;
                    end
                    else
                    begin
                        // Full table: evict the oldest entry before appending.
                        if (tab_fill >= TABLE_DEPTH)
                            drop_entry(0);
                        tab_id[tab_fill]  = req.element_id;
                        tab_gen[tab_fill] = cur_gen;
                        tab_cnt[tab_fill] = ust_pkg::COUNT_ONE;
                        tab_fill++;
                    end
                    outcome.answer = 1'b1;
                end
                ust_pkg::OP_QUERY:
                    outcome.answer = (pos >= 0) && (tab_gen[pos] == cur_gen);
                default:
                begin
                    // Absent id on release leaves everything unchanged.
                    if (pos >= 0)
                    begin
                        was_current = (tab_gen[pos] == cur_gen);
                        if (tab_cnt[pos] > ust_pkg::COUNT_ONE)
                            tab_cnt[pos] = tab_cnt[pos] - ust_pkg::COUNT_ONE;
                        else
                        begin
                            drop_entry(pos);
                            outcome.answer = was_current;
                        end
                    end
                end
            endcase
        end
        for (i = 0; i < tab_fill; i++)
            if (tab_gen[i] == cur_gen)
                outcome.any_current = 1'b1;
        session_outcomes = {session_outcomes, outcome};
    endtask

    // Present one request and hold it until the edge that takes it; call at a clock edge.
    task automatic send_request(input ust_pkg::op_t op, input logic [ust_pkg::ID_W-1:0] id);
        ust_pkg::request_t req;
        req.op         = op;
        req.element_id = id;
        start   <= 1'b1;
        request <= req;
        do
            @(posedge clk);
        while (busy);
        track_session(req);
    endtask

    task automatic idle_cycles(input int n);
        start <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    // Sender pacing: bursts of random length separated by random gaps.
    task automatic pace();
        if (no_gaps)
            return;
        if (burst_left > 0)
            burst_left--;
        else
        begin
            idle_cycles($urandom_range(1, 6));
            burst_left = $urandom_range(0, 11);
        end
    endtask

    task automatic issue(input ust_pkg::op_t op, input logic [ust_pkg::ID_W-1:0] id);
        send_request(op, id);
        pace();
    endtask

    // Pick an operation by percentage weights; the remainder goes to release.
    function automatic ust_pkg::op_t pick_op(input int w_adv, input int w_reg,
                                             input int w_qry);
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < w_adv)
            return ust_pkg::OP_ADVANCE;
        if (roll < w_adv + w_reg)
            return ust_pkg::OP_REGISTER;
        if (roll < w_adv + w_reg + w_qry)
            return ust_pkg::OP_QUERY;
        return ust_pkg::OP_RELEASE;
    endfunction

    task automatic fill_pool(input int n);
        logic [ust_pkg::ID_W-1:0] fresh;
        id_pool.delete();
        repeat (n)
        begin
            fresh   = $urandom;
            id_pool = {id_pool, fresh};
        end
    endtask

    function automatic logic [ust_pkg::ID_W-1:0] pool_id();
        return id_pool[$urandom_range(0, id_pool.size() - 1)];
    endfunction

    // Every operation on the extreme ids and two pattern ids: empty table, stale and
    // current entries, decrement on release, removal of stale and of current entries, absent ids.
    task automatic test_directed_ops();
        issue(ust_pkg::OP_QUERY,    32'h0000_0000);
        issue(ust_pkg::OP_RELEASE,  32'hFFFF_FFFF);
        issue(ust_pkg::OP_ADVANCE,  32'hFFFF_FFFF);
        issue(ust_pkg::OP_REGISTER, 32'h0000_0000);
        issue(ust_pkg::OP_REGISTER, 32'hFFFF_FFFF);
        issue(ust_pkg::OP_REGISTER, 32'h0000_0000);
        issue(ust_pkg::OP_QUERY,    32'h0000_0000);
        issue(ust_pkg::OP_ADVANCE,  32'h0000_0000);
        issue(ust_pkg::OP_QUERY,    32'h0000_0000);
        issue(ust_pkg::OP_RELEASE,  32'h0000_0000);
        issue(ust_pkg::OP_REGISTER, 32'hFFFF_FFFF);
        issue(ust_pkg::OP_RELEASE,  32'h0000_0000);
        issue(ust_pkg::OP_QUERY,    32'h0000_0000);
        issue(ust_pkg::OP_RELEASE,  32'hFFFF_FFFF);
        issue(ust_pkg::OP_RELEASE,  32'hFFFF_FFFF);
        issue(ust_pkg::OP_QUERY,    32'hFFFF_FFFF);
        issue(ust_pkg::OP_REGISTER, 32'h5A5A_5A5A);
        issue(ust_pkg::OP_REGISTER, 32'hA5A5_A5A5);
        issue(ust_pkg::OP_ADVANCE,  32'h5A5A_5A5A);
        issue(ust_pkg::OP_RELEASE,  32'h5A5A_5A5A);
        issue(ust_pkg::OP_QUERY,    32'hA5A5_A5A5);
        issue(ust_pkg::OP_RELEASE,  32'hA5A5_A5A5);
    endtask

    // Few ids, so counts climb and fall and entries go stale between advances.
    task automatic test_pool_sessions(input int n);
        fill_pool(12);
        repeat (n) issue(pick_op(10, 35, 20), pool_id());
    endtask

    // More ids than slots: fill the table back to back, then keep evicting.
    task automatic test_table_overflow(input int n);
        int i;
        fill_pool(TABLE_DEPTH + 36);
        no_gaps = 1'b1;
        for (i = 0; i < TABLE_DEPTH + 4; i++)
            issue(ust_pkg::OP_REGISTER, id_pool[i]);
        no_gaps = 1'b0;
        repeat (n) issue(pick_op(8, 60, 16), pool_id());
    endtask

    // Uniform operations, half of them on ids the table has never seen.
    task automatic test_noise(input int n);
        logic [ust_pkg::ID_W-1:0] id;
        repeat (n)
        begin
            id = $urandom_range(0, 1) ? pool_id() : $urandom;
            issue(ust_pkg::op_t'($urandom_range(0, 3)), id);
        end
    endtask

    // Take each result on the edge that ends its strobe cycle; drop it against the oldest outcome.
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (session_outcomes.size() == 0)
                report_mismatch("result with nothing expected, done", done, 1'b0);
            else
            begin
                if (result.answer !== session_outcomes[0].answer)
                    report_mismatch("answer", result.answer, session_outcomes[0].answer);
                if (result.found !== session_outcomes[0].found)
                    report_mismatch("found", result.found, session_outcomes[0].found);
                if (result.any_current !== session_outcomes[0].any_current)
                    report_mismatch("any_current", result.any_current,
                                    session_outcomes[0].any_current);
                void'(session_outcomes.pop_front());
            end
        end
    end

    initial
    begin
        cycle_count    = 0;
        mismatch_count = 0;
        tab_fill       = 0;
        cur_gen        = ust_pkg::GEN_ZERO;
        burst_left     = 0;
        no_gaps        = 1'b0;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_ops();
        test_pool_sessions(300);
        test_table_overflow(220);
        test_noise(150);
        idle_cycles(0);

        // Drain: wait for every outstanding result, then a few cycles for stray strobes.
        while (session_outcomes.size() != 0)
            @(posedge clk);
        repeat (6) @(posedge clk);

        if (mismatch_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

>>> ui_element_session_tracker.f
design/ust_pkg.sv
design/ust_cell.sv
design/ui_element_session_tracker.sv
design/ust_checker.sv
verif/ui_element_session_tracker_tb.sv
